// ===== rtl/ned_pkg.sv =====
//------------------------------------------------------------------------------
// ned_pkg
// Shared types, constants and character helpers of the normalized edit
// distance matcher.
//------------------------------------------------------------------------------
`default_nettype none

package ned_pkg;

    localparam int MAX_LEN_DEF = 64;

    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int THRESH_W   = 7;
    localparam int DIST_W     = 7;
    localparam int DIST_MAX   = (2 ** DIST_W) - 1;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;

    localparam logic [THRESH_W-1:0] THRESHOLD_RST = 7'd2;

    localparam logic [FUNC_W-1:0] FUNC_APPEND_CAND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND_REF  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVAL        = 2'd2;

    // Append and clear requests for one string store
    typedef struct packed {
        logic              append;
        logic              clear;
        logic [CHAR_W-1:0] code;
    } str_ctrl_t;

    // Space, tab, LF, VT, FF and CR
    function automatic logic is_blank(input logic [CHAR_W-1:0] code);
        return (code == 8'h20) || ((code >= 8'h09) && (code <= 8'h0D));
    endfunction

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] res;
        res = code;
        if ((code >= 8'h41) && (code <= 8'h5A)) begin
            res = code + 8'h20;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ned_char_store.sv =====
//------------------------------------------------------------------------------
// ned_char_store
// One normalized string: character memory with its fill length. Blanks are
// dropped, upper case is lowered, appends to a full string raise drop.
//------------------------------------------------------------------------------
`default_nettype none

module ned_char_store #(
    parameter int MAX_LEN = ned_pkg::MAX_LEN_DEF,
    parameter int LEN_W   = $clog2(MAX_LEN + 1),
    parameter int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  ned_pkg::str_ctrl_t     ctrl,
    input  wire                          rd_en,
    input  wire  [ADDR_W-1:0]            rd_addr,
    output logic [ned_pkg::CHAR_W-1:0]   rd_data,
    output logic [LEN_W-1:0]             length,
    output logic                         drop
);

    logic [ned_pkg::CHAR_W-1:0] mem [MAX_LEN];
    logic [ned_pkg::CHAR_W-1:0] rd_data_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [LEN_W-1:0]           len_next;
    logic                       keep;
    logic                       full;
    logic                       wr_en;

    assign keep  = ctrl.append && !ned_pkg::is_blank(ctrl.code);
    assign full  = (len_reg == LEN_W'(MAX_LEN));
    assign wr_en = keep && !full;
    assign drop  = keep && full;

    always_comb begin
        len_next = len_reg;
        if (ctrl.clear) begin
            len_next = '0;
        end else if (wr_en) begin
            len_next = len_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[len_reg[ADDR_W-1:0]] <= ned_pkg::fold_case(ctrl.code);
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign length  = len_reg;

endmodule

`default_nettype wire

// ===== rtl/ned_cost_mem.sv =====
//------------------------------------------------------------------------------
// ned_cost_mem
// Working cost row of the distance table: one write port and one registered
// read port.
//------------------------------------------------------------------------------
`default_nettype none

module ned_cost_mem #(
    parameter int DEPTH  = ned_pkg::MAX_LEN_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DATA_W = $clog2(DEPTH + 1)
) (
    input  wire                 aclk,
    input  wire                 wr_en,
    input  wire  [ADDR_W-1:0]   wr_addr,
    input  wire  [DATA_W-1:0]   wr_data,
    input  wire                 rd_en,
    input  wire  [ADDR_W-1:0]   rd_addr,
    output logic [DATA_W-1:0]   rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/normalized_edit_distance_matcher.sv =====
//------------------------------------------------------------------------------
// normalized_edit_distance_matcher
// Levenshtein distance between a candidate and a reference string built up
// one character per transfer.
//------------------------------------------------------------------------------
// Appends (tuser 0 candidate, 1 reference) are accepted back to back while
// idle. An evaluate (tuser 2) holds the input until its result is loaded
// into the output register; when either string is empty the table walk is
// skipped. The cost row lives in one memory with a single read and a single
// write port, so the table is walked one cell per cycle, with an extra ROW
// state per row to fetch that row's candidate character. The result sits
// in an output register, so further appends are taken while it waits.
`default_nettype none

module normalized_edit_distance_matcher #(
    parameter int MAX_LEN = ned_pkg::MAX_LEN_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // configuration: threshold
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [ned_pkg::THRESH_W-1:0]     cfg_data,
    // input stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [ned_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] char_code
    input  wire  [ned_pkg::FUNC_W-1:0]       s_tuser,   // [1:0] func
    // result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [ned_pkg::M_TDATA_W-1:0]    m_tdata    // [6:0] distance, [7] similar,
                                                        // [8] overflow, [15:9] zero
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int COST_W = LEN_W;
    localparam int CMP_W  = (COST_W > ned_pkg::DIST_W) ? COST_W : ned_pkg::DIST_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROW   = 3'd1;
    localparam logic [2:0] ST_CELL  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [ADDR_W-1:0]             row_reg, row_next;
    logic [ADDR_W-1:0]             col_reg, col_next;
    logic [LEN_W-1:0]              m_len_reg, m_len_next;
    logic [LEN_W-1:0]              n_len_reg, n_len_next;
    logic                          dropped_reg, dropped_next;
    logic                          run_ovf_reg, run_ovf_next;
    logic                          p_vld_reg;
    logic [ADDR_W-1:0]             p_col_reg;
    logic                          p_first_reg;
    logic [COST_W-1:0]             diag_reg, diag_next;
    logic [COST_W-1:0]             left_reg, left_next;
    logic [COST_W-1:0]             dist_reg, dist_next;
    logic [ned_pkg::THRESH_W-1:0]  threshold_reg;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [ned_pkg::DIST_W-1:0]    m_dist_reg, m_dist_next;
    logic                          m_sim_reg, m_sim_next;
    logic                          m_ovf_reg, m_ovf_next;

    logic                          in_xfer;
    logic [ned_pkg::FUNC_W-1:0]    func;
    ned_pkg::str_ctrl_t            cand_ctrl, ref_ctrl;
    logic                          cand_rd_en, cell_rd_en;
    logic [ned_pkg::CHAR_W-1:0]    cand_char, ref_char;
    logic [LEN_W-1:0]              cand_len, ref_len;
    logic                          cand_drop, ref_drop;
    logic [COST_W-1:0]             cost_rd;
    logic [COST_W-1:0]             above;
    logic [COST_W-1:0]             best;
    logic [COST_W-1:0]             new_cost;
    logic                          col_last, row_last;
    logic                          out_load;
    logic [CMP_W-1:0]              dist_ext;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign func      = s_tuser;

    always_comb begin
        cand_ctrl.append = in_xfer && (func == ned_pkg::FUNC_APPEND_CAND);
        cand_ctrl.clear  = in_xfer && (func == ned_pkg::FUNC_EVAL);
        cand_ctrl.code   = s_tdata[ned_pkg::CHAR_W-1:0];
        ref_ctrl.append  = in_xfer && (func == ned_pkg::FUNC_APPEND_REF);
        ref_ctrl.clear   = in_xfer && (func == ned_pkg::FUNC_EVAL);
        ref_ctrl.code    = s_tdata[ned_pkg::CHAR_W-1:0];
    end

    assign cand_rd_en = (state_reg == ST_ROW);
    assign cell_rd_en = (state_reg == ST_CELL);

    ned_char_store #(
        .MAX_LEN (MAX_LEN),
        .LEN_W   (LEN_W),
        .ADDR_W  (ADDR_W)
    ) u_cand (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cand_ctrl),
        .rd_en   (cand_rd_en),
        .rd_addr (row_reg),
        .rd_data (cand_char),
        .length  (cand_len),
        .drop    (cand_drop)
    );

    ned_char_store #(
        .MAX_LEN (MAX_LEN),
        .LEN_W   (LEN_W),
        .ADDR_W  (ADDR_W)
    ) u_ref (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ref_ctrl),
        .rd_en   (cell_rd_en),
        .rd_addr (col_reg),
        .rd_data (ref_char),
        .length  (ref_len),
        .drop    (ref_drop)
    );

    // Entry j holds the cost of column j+1; column zero is implied by the row.
    ned_cost_mem #(
        .DEPTH   (MAX_LEN),
        .ADDR_W  (ADDR_W),
        .DATA_W  (COST_W)
    ) u_cost (
        .aclk    (aclk),
        .wr_en   (p_vld_reg),
        .wr_addr (p_col_reg),
        .wr_data (new_cost),
        .rd_en   (cell_rd_en),
        .rd_addr (col_reg),
        .rd_data (cost_rd)
    );

    // Cell update; the first row sees the initial row j+1 instead of memory.
    always_comb begin
        above = p_first_reg ? (COST_W'(p_col_reg) + COST_W'(1)) : cost_rd;
        best  = above;
        if (left_reg < best) begin
            best = left_reg;
        end
        if (diag_reg < best) begin
            best = diag_reg;
        end
        new_cost = (cand_char == ref_char) ? diag_reg : (best + COST_W'(1));
    end

    assign col_last = (LEN_W'(col_reg) == (n_len_reg - LEN_W'(1)));
    assign row_last = (LEN_W'(row_reg) == (m_len_reg - LEN_W'(1)));

    assign dist_ext = CMP_W'(dist_reg);
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        m_len_next    = m_len_reg;
        n_len_next    = n_len_reg;
        dropped_next  = dropped_reg || cand_drop || ref_drop;
        run_ovf_next  = run_ovf_reg;
        diag_next     = diag_reg;
        left_next     = left_reg;
        dist_next     = dist_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_dist_next   = m_dist_reg;
        m_sim_next    = m_sim_reg;
        m_ovf_next    = m_ovf_reg;

        if (p_vld_reg) begin
            left_next = new_cost;
            diag_next = above;
            dist_next = new_cost;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cand_ctrl.clear) begin
                    m_len_next   = cand_len;
                    n_len_next   = ref_len;
                    run_ovf_next = dropped_reg;
                    dropped_next = 1'b0;
                    row_next     = '0;
                    if ((cand_len == '0) || (ref_len == '0)) begin
                        // one side empty: distance is the other length
                        dist_next  = COST_W'(cand_len + ref_len);
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW: begin
                // seed the row; overrides the tail cell of the previous row
                diag_next  = COST_W'(row_reg);
                left_next  = COST_W'(row_reg) + COST_W'(1);
                col_next   = '0;
                state_next = ST_CELL;
            end
            ST_CELL: begin
                if (col_last) begin
                    if (row_last) begin
                        state_next = ST_FLUSH;
                    end else begin
                        row_next   = row_reg + ADDR_W'(1);
                        state_next = ST_ROW;
                    end
                end else begin
                    col_next = col_reg + ADDR_W'(1);
                end
            end
            ST_FLUSH: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_dist_next   = (dist_ext > CMP_W'(ned_pkg::DIST_MAX))
                                    ? ned_pkg::DIST_W'(ned_pkg::DIST_MAX)
                                    : ned_pkg::DIST_W'(dist_ext);
                    m_sim_next    = (dist_ext <= CMP_W'(threshold_reg));
                    m_ovf_next    = run_ovf_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dropped_reg   <= 1'b0;
            p_vld_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            threshold_reg <= ned_pkg::THRESHOLD_RST;
        end else begin
            state_reg    <= state_next;
            dropped_reg  <= dropped_next;
            p_vld_reg    <= cell_rd_en;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                threshold_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        m_len_reg   <= m_len_next;
        n_len_reg   <= n_len_next;
        run_ovf_reg <= run_ovf_next;
        diag_reg    <= diag_next;
        left_reg    <= left_next;
        dist_reg    <= dist_next;
        m_dist_reg  <= m_dist_next;
        m_sim_reg   <= m_sim_next;
        m_ovf_reg   <= m_ovf_next;
        if (cell_rd_en) begin
            p_col_reg   <= col_reg;
            p_first_reg <= (row_reg == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_ovf_reg, m_sim_reg, m_dist_reg};

endmodule

`default_nettype wire
